[rtl/core/ohce_pkg.sv]
// Package: shared types and codes of the one-hot category encoder.
package ohce_pkg;

    localparam int VALUE_W  = 32;
    localparam int FEAT_W   = 4;
    localparam int NF_W     = 5;
    localparam int COL_W    = 10;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DROP_FIRST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd1;

    localparam logic FUNC_FIT       = 1'b0;
    localparam logic FUNC_TRANSFORM = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FEAT  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_LOAD = 10'b00_0000_0010,
        ST_RD   = 10'b00_0000_0100,
        ST_CMP  = 10'b00_0000_1000,
        ST_DEC  = 10'b00_0001_0000,
        ST_SHR  = 10'b00_0010_0000,
        ST_SHW  = 10'b00_0100_0000,
        ST_INS  = 10'b00_1000_0000,
        ST_SUM  = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } state_t;

endpackage

[rtl/core/ohce_if.sv]
// Interfaces: sample, result and configuration channels.
interface ohce_sample_if
    import ohce_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic                      first_of_set;
    logic                      last_of_set;
    logic [FEAT_W-1:0]         feature_index;
    logic signed [VALUE_W-1:0] sample_value;

    modport source (output valid, func, first_of_set, last_of_set, feature_index,
                    sample_value, input ready);
    modport sink   (input valid, func, first_of_set, last_of_set, feature_index,
                    sample_value, output ready);
endinterface

interface ohce_result_if
    import ohce_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COL_W-1:0]     column_index;
    logic                 hit;
    logic [STATUS_W-1:0]  status;
    logic [TOTAL_W-1:0]   total_columns;

    modport source (output valid, column_index, hit, status, total_columns, input ready);
    modport sink   (input valid, column_index, hit, status, total_columns, output ready);
endinterface

interface ohce_cfg_if
    import ohce_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/one_hot_category_encoder.sv]
// Top level: one-hot category encoder with drop-first, table kept in one RAM.
// Throughput: one item at a time; the single RAM port pair and the count adder set it.
// A new item is taken while the previous result waits in the output register.
// Reset clears counts, fitted flag, state, result valid at once; RAM needs no clearing.
module one_hot_category_encoder
    import ohce_pkg::*;
#(
    parameter int MAX_FEATURES   = 16,
    parameter int MAX_CATEGORIES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    ohce_sample_if.sink    sample,
    ohce_result_if.source  result,
    ohce_cfg_if.sink       cfg
);
    localparam int DEPTH  = MAX_FEATURES * MAX_CATEGORIES;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_CATEGORIES + 1);
    localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SW     = $clog2(DEPTH + 1);
    localparam int MF_CAP = (MAX_FEATURES < 31) ? MAX_FEATURES : 31;

    state_t state_reg, state_next;

    // item fields held for the whole item
    logic                      func_reg, first_reg, last_reg;
    logic [FEAT_W-1:0]         f_reg;
    logic signed [VALUE_W-1:0] v_reg;
    logic [NF_W-1:0]           nf_reg;
    logic [AW-1:0]             base_reg;

    // search and shift counters
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] j_reg, j_next;
    logic          found_reg, found_next;
    logic [NF_W-1:0] k_reg, k_next;
    logic [SW-1:0] total_reg, total_next;
    logic [SW-1:0] before_reg, before_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // per-feature counts and flags
    logic [CW-1:0] cnt_reg [MAX_FEATURES];
    logic [CW-1:0] cnt_next [MAX_FEATURES];
    logic          fitted_reg, fitted_next;
    logic          drop_reg;
    logic [NF_W-1:0] fcount_reg;

    // result register
    logic                res_valid_reg, res_valid_next;
    logic [COL_W-1:0]    res_col_reg, res_col_next;
    logic                res_hit_reg, res_hit_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TOTAL_W-1:0]  res_total_reg, res_total_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    logic          in_accept;
    logic [FW-1:0] cnt_sel;
    logic [CW-1:0] cnt_rd;
    logic [CW-1:0] cols_k;
    logic [NF_W-1:0] nf_now;
    logic          feat_bad;
    logic          res_load;
    logic [SW:0]   col_full;

    ohce_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign in_accept    = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid         = res_valid_reg;
    assign result.column_index  = res_col_reg;
    assign result.hit           = res_hit_reg;
    assign result.status        = res_status_reg;
    assign result.total_columns = res_total_reg;

    // one count read port: the feature of the item, or the running feature while summing
    assign cnt_sel = (state_reg == ST_SUM) ? FW'(k_reg) : FW'(f_reg);
    assign cnt_rd  = cnt_reg[cnt_sel];
    assign cols_k  = (drop_reg && (cnt_rd != '0)) ? cnt_rd - CW'(1) : cnt_rd;

    // clamp the configured feature count to the table size, at most 31
    assign nf_now   = (32'(fcount_reg) > MF_CAP) ? NF_W'(MF_CAP) : fcount_reg;
    assign feat_bad = (NF_W'(f_reg) >= nf_reg);

    assign col_full = (SW+1)'(before_reg) + (SW+1)'(pos_reg) - (SW+1)'(drop_reg);
    assign res_load = (state_reg == ST_FIN) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        found_next      = found_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        before_next     = before_reg;
        status_next     = status_reg;
        fitted_next     = fitted_reg;
        cnt_next        = cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = base_reg + AW'(pos_reg);
        ram_wdata       = v_reg;
        ram_raddr       = base_reg + AW'(i_reg);
        res_valid_next  = res_valid_reg;
        res_col_next    = res_col_reg;
        res_hit_next    = res_hit_reg;
        res_status_next = res_status_reg;
        res_total_next  = res_total_reg;

        // drop the result once taken; a new one may overwrite below
        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    total_next  = '0;
                    before_next = '0;
                    i_next      = '0;
                    k_next      = '0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (func_reg == FUNC_FIT)
                begin
                    if (feat_bad)
                    begin
                        status_next = STATUS_BAD_FEAT;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            for (int q = 0; q < MAX_FEATURES; q++)
                            begin
                                cnt_next[q] = '0;
                            end
                            fitted_next = 1'b0;
                            n_next      = '0;
                        end
                        else
                        begin
                            n_next = cnt_rd;
                        end
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    if (!fitted_reg)
                    begin
                        status_next = STATUS_NOT_FIT;
                        state_next  = ST_FIN;
                    end
                    else if (feat_bad)
                    begin
                        status_next = STATUS_BAD_FEAT;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        n_next     = cnt_rd;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                // end of table: the value goes after every stored entry
                if (i_reg == n_reg)
                begin
                    pos_next   = i_reg;
                    found_next = 1'b0;
                    state_next = ST_DEC;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if ($signed(ram_rdata) >= v_reg)
                begin
                    pos_next   = i_reg;
                    found_next = ($signed(ram_rdata) == v_reg);
                    state_next = ST_DEC;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_RD;
                end
            end
            ST_DEC:
            begin
                if (func_reg == FUNC_TRANSFORM)
                begin
                    state_next = ST_SUM;
                end
                else if (found_reg)
                begin
                    fitted_next = fitted_reg || last_reg;
                    state_next  = ST_SUM;
                end
                else if (32'(n_reg) >= MAX_CATEGORIES)
                begin
                    status_next = STATUS_FULL;
                    fitted_next = fitted_reg || last_reg;
                    state_next  = ST_SUM;
                end
                else
                begin
                    j_next     = n_reg;
                    state_next = ST_SHR;
                end
            end
            ST_SHR:
            begin
                ram_raddr = base_reg + AW'(j_reg) - AW'(1);
                if (j_reg == pos_reg)
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    state_next = ST_SHW;
                end
            end
            ST_SHW:
            begin
                // move entry j-1 up to j
                ram_we     = 1'b1;
                ram_waddr  = base_reg + AW'(j_reg);
                ram_wdata  = ram_rdata;
                j_next     = j_reg - CW'(1);
                state_next = ST_SHR;
            end
            ST_INS:
            begin
                ram_we       = 1'b1;
                cnt_next[FW'(f_reg)] = n_reg + CW'(1);
                fitted_next  = fitted_reg || last_reg;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                if (k_reg == nf_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    if (NF_W'(f_reg) == k_reg)
                    begin
                        before_next = total_reg;
                    end
                    total_next = total_reg + SW'(cols_k);
                    k_next     = k_reg + NF_W'(1);
                end
            end
            ST_FIN:
            begin
                if (res_load)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_total_next  = TOTAL_W'(total_reg);
                    res_hit_next    = 1'b0;
                    res_col_next    = '0;
                    if (func_reg == FUNC_TRANSFORM && found_reg
                        && !(drop_reg && pos_reg == '0))
                    begin
                        res_hit_next = 1'b1;
                        res_col_next = COL_W'(col_full);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fitted_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            fcount_reg    <= NF_W'(1);
            res_valid_reg <= 1'b0;
            for (int q = 0; q < MAX_FEATURES; q++)
            begin
                cnt_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fitted_reg    <= fitted_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_DROP_FIRST)
                begin
                    drop_reg <= cfg.data[0];
                end
                else if (cfg.index == CFG_FEATURE_COUNT)
                begin
                    fcount_reg <= cfg.data;
                end
            end
        end
    end

    // datapath registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg  <= sample.func;
            first_reg <= sample.first_of_set;
            last_reg  <= sample.last_of_set;
            f_reg     <= sample.feature_index;
            v_reg     <= sample.sample_value;
            nf_reg    <= nf_now;
            base_reg  <= AW'(32'(sample.feature_index) * MAX_CATEGORIES);
        end
        n_reg          <= n_next;
        i_reg          <= i_next;
        pos_reg        <= pos_next;
        j_reg          <= j_next;
        found_reg      <= found_next;
        k_reg          <= k_next;
        total_reg      <= total_next;
        before_reg     <= before_next;
        status_reg     <= status_next;
        res_col_reg    <= res_col_next;
        res_hit_reg    <= res_hit_next;
        res_status_reg <= res_status_next;
        res_total_reg  <= res_total_next;
    end

    a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_LOAD)
        else $error("item accepted but sequencer did not start");

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SHW || state_reg == ST_INS))
        else $error("value RAM written outside shift or insert");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS |-> 32'(n_reg) < MAX_CATEGORIES)
        else $error("insert into a full table");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_hit_next) |-> status_reg == STATUS_OK)
        else $error("hit reported with error status");
endmodule

[rtl/core/ohce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ohce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
